### src/monotone_polygon_triangulator_core_defines.svh
// Assertion macros shared by the triangulator RTL.
`ifndef MONOTONE_POLYGON_TRIANGULATOR_CORE_DEFINES_SVH
`define MONOTONE_POLYGON_TRIANGULATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MPT_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define MPT_CHECK_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define MPT_CHECK(label, cond)
`define MPT_CHECK_NEXT(label, pre, post)
`endif
`endif

### src/mpt_pkg.sv
// Shared types, constants and helpers of the polygon triangulator.
`default_nettype none
package mpt_pkg;
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_BITS   = 16;
    localparam int CORNER_W         = 6;
    localparam int STATUS_W         = 2;
    localparam int IN_COORD_W       = 16;
    localparam int IN_TDATA_W       = 32;
    localparam int OUT_TDATA_W      = 24;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_MANY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LESS,
        S_POPCHK,
        S_TURN0,
        S_TURN1,
        S_TURN2,
        S_TURN3,
        S_EMIT,
        S_POP,
        S_POP_WAIT,
        S_FLUSH,
        S_FLUSH_DONE,
        S_PUSH2,
        S_END,
        S_ERR
    } state_t;

    typedef struct packed {
        logic [CORNER_W-1:0] a;
        logic [CORNER_W-1:0] b;
        logic [CORNER_W-1:0] c;
    } tri_t;

    // Rotates a triangle so that its smallest index leads, keeping the winding.
    function automatic tri_t rotate_tri(input tri_t t);
        tri_t r;
        logic [CORNER_W-1:0] min_ac;
        logic [CORNER_W-1:0] min_ab;
        min_ac = (t.a < t.c) ? t.a : t.c;
        min_ab = (t.a < t.b) ? t.a : t.b;
        if (t.b < min_ac)
        begin
            r.a = t.b;
            r.b = t.c;
            r.c = t.a;
        end
        else if (t.c < min_ab)
        begin
            r.a = t.c;
            r.b = t.a;
            r.c = t.b;
        end
        else
        begin
            r = t;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### src/mpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/mpt_front.sv
// Front end: takes vertex requests, fills the vertex store and issues polygon jobs.
`default_nettype none
module mpt_front #(
    parameter int MAX_VERTICES = mpt_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = mpt_pkg::DEF_COORD_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mpt_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire logic                                s_tlast,
    input  wire logic                                queue_empty,
    input  wire logic                                back_busy,
    output logic                                     store_we,
    output logic [$clog2(MAX_VERTICES)-1:0]          store_waddr,
    output logic [2*COORD_BITS-1:0]                  store_wdata,
    output logic                                     job_push,
    output logic [$clog2(MAX_VERTICES+1)+mpt_pkg::STATUS_W-1:0] job_data
);
    import mpt_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] n_final;
    status_t          job_status;
    logic signed [COORD_BITS-1:0] x_c, y_c;

    // The store is shared with the back end, so no vertex is taken while a job is pending.
    assign s_tready = queue_empty && !back_busy;
    assign accept   = s_tvalid && s_tready;
    assign room     = count_reg < CNT_W'(MAX_VERTICES);

    // The top bit of the kept coordinate bits is the sign.
    assign x_c = COORD_BITS'(s_tdata[IN_COORD_W-1:0]);
    assign y_c = COORD_BITS'(s_tdata[2*IN_COORD_W-1:IN_COORD_W]);

    assign store_we    = accept && room;
    assign store_waddr = count_reg[IDX_W-1:0];
    assign store_wdata = {y_c, x_c};

    assign n_final = room ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        if (ovf_reg || !room)
        begin
            job_status = ST_MANY;
        end
        else if (n_final < CNT_W'(3))
        begin
            job_status = ST_FEW;
        end
        else
        begin
            job_status = ST_OK;
        end
    end

    assign job_push = accept && s_tlast;
    assign job_data = {job_status, n_final};

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end
endmodule
`default_nettype wire

### src/mpt_queue.sv
// Two-entry job queue between the front and back ends.
`default_nettype none
module mpt_queue #(
    parameter int WIDTH = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  valid,
    output logic                  empty,
    output logic [WIDTH-1:0]      pop_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign do_push  = push && (fill_reg != 2'd2);
    assign do_pop   = pop && (fill_reg != 2'd0);
    assign valid    = fill_reg != 2'd0;
    assign empty    = fill_reg == 2'd0;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end
endmodule
`default_nettype wire

### src/mpt_back.sv
// Back end: chain-merging sweep with a vertex stack, orientation unit and result stage.
`default_nettype none
`include "monotone_polygon_triangulator_core_defines.svh"
module mpt_back #(
    parameter int MAX_VERTICES = mpt_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = mpt_pkg::DEF_COORD_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                job_valid,
    input  wire logic [$clog2(MAX_VERTICES+1)+mpt_pkg::STATUS_W-1:0] job_data,
    output logic                                     job_pop,
    output logic                                     busy,
    output logic [$clog2(MAX_VERTICES)-1:0]          raddr_a,
    output logic [$clog2(MAX_VERTICES)-1:0]          raddr_b,
    output logic [$clog2(MAX_VERTICES)-1:0]          raddr_c,
    input  wire logic [2*COORD_BITS-1:0]             rdata_a,
    input  wire logic [2*COORD_BITS-1:0]             rdata_b,
    input  wire logic [2*COORD_BITS-1:0]             rdata_c,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mpt_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                     m_tlast
);
    import mpt_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int SE_W  = 1 + 2 * IDX_W;
    localparam int D_W   = COORD_BITS + 1;
    localparam int P_W   = 2 * D_W;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [CNT_W-1:0] n_reg, n_next;
    status_t          status_reg, status_next;
    logic [IDX_W-1:0] lo_reg, lo_next, up_reg, up_next;
    logic [IDX_W-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [SE_W-1:0]  top_reg, top_next;
    logic             flush_reg, flush_next, final_reg, final_next;
    logic [IDX_W-1:0] ta_reg, ta_next, tb_reg, tb_next, tc_reg, tc_next;
    logic signed [D_W-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [P_W-1:0] p1_reg, p2_reg;
    tri_t             tri_reg, tri_next;
    tri_t             hold_reg, hold_next;
    logic             hold_valid_reg, hold_valid_next;
    tri_t             out_reg, out_next;
    status_t          out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;
    logic             out_valid_reg, out_valid_next;

    // Stack port
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr, stk_raddr;
    logic [SE_W-1:0]  stk_rdata;

    // Decisions
    logic             out_free;
    logic [SE_W-1:0]  top_eff;
    logic             top_has;
    logic [IDX_W-1:0] top_base, top_tip;
    logic signed [COORD_BITS-1:0] lx, ly, ux, uy;
    logic             lo_less;
    logic [IDX_W-1:0] pick;
    logic             pick_nb;
    logic             neg;
    logic             push_en;
    logic [SE_W-1:0]  push_val;
    logic [CNT_W-1:0] depth_m1, depth_m2;
    tri_t             tri_raw;
    status_t          job_status;
    logic [CNT_W-1:0] job_n;

    function automatic logic adjacent(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                                      input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] an, bn, a1, b1;
        an = CNT_W'(a);
        bn = CNT_W'(b);
        a1 = (an + CNT_W'(1) == n) ? '0 : an + CNT_W'(1);
        b1 = (bn + CNT_W'(1) == n) ? '0 : bn + CNT_W'(1);
        return (a1 == bn) || (b1 == an);
    endfunction

    assign job_status = status_t'(job_data[CNT_W+STATUS_W-1:CNT_W]);
    assign job_n      = job_data[CNT_W-1:0];

    assign out_free = !out_valid_reg || m_tready;
    assign top_eff  = (depth_reg == '0) ? '0 : top_reg;
    assign top_has  = top_eff[SE_W-1];
    assign top_base = top_eff[2*IDX_W-1:IDX_W];
    assign top_tip  = top_eff[IDX_W-1:0];
    assign depth_m1 = depth_reg - CNT_W'(1);
    assign depth_m2 = depth_reg - CNT_W'(2);

    assign lx = rdata_a[COORD_BITS-1:0];
    assign ly = rdata_a[2*COORD_BITS-1:COORD_BITS];
    assign ux = rdata_b[COORD_BITS-1:0];
    assign uy = rdata_b[2*COORD_BITS-1:COORD_BITS];
    // Equal keys take the upper chain.
    assign lo_less = (lx < ux) || ((lx == ux) && (ly < uy));
    assign pick    = lo_less ? lo_reg : up_reg;
    assign pick_nb = adjacent(pick, top_tip, n_reg);
    assign neg     = p1_reg < p2_reg;

    // A negative turn swaps the outer corners to make the triangle counter-clockwise.
    always_comb
    begin
        tri_raw.a = neg ? CORNER_W'(tc_reg) : CORNER_W'(ta_reg);
        tri_raw.b = CORNER_W'(tb_reg);
        tri_raw.c = neg ? CORNER_W'(ta_reg) : CORNER_W'(tc_reg);
    end

    assign raddr_a   = (state_reg == S_CHECK) ? lo_reg : ta_reg;
    assign raddr_b   = (state_reg == S_CHECK) ? up_reg : tb_reg;
    assign raddr_c   = tc_reg;
    assign stk_raddr = depth_m2[IDX_W-1:0];
    assign stk_waddr = depth_m1[IDX_W-1:0];

    assign busy     = state_reg != S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_status_reg, out_reg.c, out_reg.b, out_reg.a});
    assign m_tlast  = out_last_reg;

    mpt_ram #(
        .WIDTH(SE_W),
        .DEPTH(MAX_VERTICES)
    ) u_stack (
        .clk  (clk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(top_reg),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = (job_status == ST_OK) ? S_CHECK : S_ERR;
                end
            end
            S_CHECK:      state_next = (lo_reg == up_reg) ? S_FLUSH : S_LESS;
            S_LESS:       state_next = pick_nb ? S_POPCHK : S_FLUSH;
            S_POPCHK:     state_next = top_has ? S_TURN0 : S_CHECK;
            S_TURN0:      state_next = S_TURN1;
            S_TURN1:      state_next = S_TURN2;
            S_TURN2:      state_next = S_TURN3;
            S_TURN3:      state_next = (flush_reg || neg) ? S_EMIT : S_CHECK;
            S_EMIT:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:        state_next = S_POP_WAIT;
            S_POP_WAIT:   state_next = ret_reg;
            S_FLUSH:
            begin
                if (top_has)
                begin
                    state_next = S_TURN0;
                end
                else if (depth_reg != '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_FLUSH_DONE;
                end
            end
            S_FLUSH_DONE: state_next = final_reg ? S_END : S_PUSH2;
            S_PUSH2:      state_next = S_CHECK;
            S_END:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        ret_next        = ret_reg;
        n_next          = n_reg;
        status_next     = status_reg;
        lo_next         = lo_reg;
        up_next         = up_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        depth_next      = depth_reg;
        top_next        = top_reg;
        flush_next      = flush_reg;
        final_next      = final_reg;
        ta_next         = ta_reg;
        tb_next         = tb_reg;
        tc_next         = tc_reg;
        tri_next        = tri_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        job_pop         = 1'b0;
        push_en         = 1'b0;
        push_val        = '0;
        stk_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop     = 1'b1;
                    n_next      = job_n;
                    status_next = job_status;
                    depth_next  = CNT_W'(1);
                    top_next    = '0;
                    lo_next     = IDX_W'(1);
                    up_next     = IDX_W'(job_n - CNT_W'(1));
                end
            end
            S_CHECK:
            begin
                if (lo_reg == up_reg)
                begin
                    cur_next   = lo_reg;
                    flush_next = 1'b1;
                    final_next = 1'b1;
                end
            end
            S_LESS:
            begin
                cur_next = pick;
                if (lo_less)
                begin
                    lo_next = lo_reg + IDX_W'(1);
                end
                else
                begin
                    up_next = up_reg - IDX_W'(1);
                end
                if (!pick_nb)
                begin
                    prev_next  = top_tip;
                    flush_next = 1'b1;
                    final_next = 1'b0;
                end
                else
                begin
                    flush_next = 1'b0;
                end
            end
            S_POPCHK:
            begin
                if (top_has)
                begin
                    ta_next = top_base;
                    tb_next = top_tip;
                    tc_next = cur_reg;
                end
                else
                begin
                    push_en  = 1'b1;
                    push_val = {1'b1, top_tip, cur_reg};
                end
            end
            S_TURN0:
            begin
            end
            S_TURN1:
            begin
            end
            S_TURN2:
            begin
            end
            S_TURN3:
            begin
                if (flush_reg || neg)
                begin
                    tri_next = rotate_tri(tri_raw);
                end
                else
                begin
                    push_en  = 1'b1;
                    push_val = {1'b1, top_tip, cur_reg};
                end
            end
            S_EMIT:
            begin
                // The previous triangle leaves only once another one follows it or the sweep ends.
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next        = hold_reg;
                        out_status_next = ST_OK;
                        out_last_next   = 1'b0;
                        out_valid_next  = 1'b1;
                    end
                    hold_next       = tri_reg;
                    hold_valid_next = 1'b1;
                    ret_next        = flush_reg ? S_FLUSH : S_POPCHK;
                end
            end
            S_POP:
            begin
                depth_next = depth_m1;
            end
            S_POP_WAIT:
            begin
                if (depth_reg != '0)
                begin
                    top_next = stk_rdata;
                end
            end
            S_FLUSH:
            begin
                if (top_has)
                begin
                    ta_next = top_base;
                    tb_next = top_tip;
                    tc_next = cur_reg;
                end
                else if (depth_reg != '0)
                begin
                    ret_next = S_FLUSH_DONE;
                end
            end
            S_FLUSH_DONE:
            begin
                if (!final_reg)
                begin
                    push_en  = 1'b1;
                    push_val = {1'b0, {IDX_W{1'b0}}, prev_reg};
                end
            end
            S_PUSH2:
            begin
                push_en  = 1'b1;
                push_val = {1'b1, prev_reg, cur_reg};
            end
            S_END:
            begin
                if (hold_valid_reg && out_free)
                begin
                    out_next        = hold_reg;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_next        = '0;
                    out_status_next = status_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // A push onto a full stack is dropped.
        if (push_en && (depth_reg < CNT_W'(MAX_VERTICES)))
        begin
            stk_we     = depth_reg != '0;
            top_next   = push_val;
            depth_next = depth_reg + CNT_W'(1);
        end
    end

    // Orientation unit: differences, then products, then the sign compare in S_TURN3.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TURN1)
        begin
            dx1_reg <= {rdata_b[COORD_BITS-1], rdata_b[COORD_BITS-1:0]}
                     - {rdata_a[COORD_BITS-1], rdata_a[COORD_BITS-1:0]};
            dy1_reg <= {rdata_b[2*COORD_BITS-1], rdata_b[2*COORD_BITS-1:COORD_BITS]}
                     - {rdata_a[2*COORD_BITS-1], rdata_a[2*COORD_BITS-1:COORD_BITS]};
            dx2_reg <= {rdata_c[COORD_BITS-1], rdata_c[COORD_BITS-1:0]}
                     - {rdata_a[COORD_BITS-1], rdata_a[COORD_BITS-1:0]};
            dy2_reg <= {rdata_c[2*COORD_BITS-1], rdata_c[2*COORD_BITS-1:COORD_BITS]}
                     - {rdata_a[2*COORD_BITS-1], rdata_a[2*COORD_BITS-1:COORD_BITS]};
        end
        if (state_reg == S_TURN2)
        begin
            p1_reg <= P_W'(dx1_reg) * P_W'(dy2_reg);
            p2_reg <= P_W'(dy1_reg) * P_W'(dx2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        status_reg <= status_next;
        lo_reg     <= lo_next;
        up_reg     <= up_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        top_reg    <= top_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        tc_reg     <= tc_next;
        tri_reg    <= tri_next;
        hold_reg   <= hold_next;
        out_reg    <= out_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            depth_reg      <= '0;
            flush_reg      <= 1'b0;
            final_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            depth_reg      <= depth_next;
            flush_reg      <= flush_next;
            final_reg      <= final_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    `MPT_CHECK(a_depth_bound, depth_reg <= CNT_W'(MAX_VERTICES))
    `MPT_CHECK(a_cursor_order, (state_reg != S_CHECK) || (lo_reg <= up_reg))
    `MPT_CHECK(a_hold_idle, (state_reg != S_IDLE) || !hold_valid_reg)
    `MPT_CHECK_NEXT(a_err_once, (state_reg == S_ERR) && out_free, (state_reg == S_IDLE) && out_valid_reg && out_last_reg)
endmodule
`default_nettype wire

### src/monotone_polygon_triangulator_core.sv
// Top level of the monotone polygon triangulator.
//
//  Channel  Dir  Request contents
//  s_*      in   tdata[15:0] x_coord, tdata[31:16] y_coord, tlast final_vertex
//  m_*      out  tdata corner_a, corner_b, corner_c, status; tlast last_triangle
//
// Vertex requests are taken back to back while s_tready is high; the final one starts the sweep.
// The sweep time for each vertex and for each triangle cut off is set by the stack walk
// and the orientation unit, which reads three vertex store copies at once.
// Reset is asynchronous and clears the state machines, counters and valid flags; the vertex store is not cleared.
// New vertices are refused while a polygon is queued or being swept; a stalled result stage
// holds the sweep when two triangles wait and a third is ready, or when the last result waits.
`default_nettype none
module monotone_polygon_triangulator_core #(
    parameter int MAX_VERTICES = mpt_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = mpt_pkg::DEF_COORD_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // x_coord[15:0], y_coord[31:16]
    input  wire logic [mpt_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // corner_a[5:0], corner_b[11:6], corner_c[17:12], status[19:18], zero[23:20]
    output logic [mpt_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import mpt_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int JOB_W = CNT_W + STATUS_W;
    localparam int V_W   = 2 * COORD_BITS;

    logic             q_empty, q_valid, q_pop, job_push, back_busy;
    logic [JOB_W-1:0] job_in, job_out;
    logic             st_we;
    logic [IDX_W-1:0] st_waddr, ra, rb, rc;
    logic [V_W-1:0]   st_wdata, qa, qb, qc;

    mpt_front #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_empty(q_empty),
        .back_busy  (back_busy),
        .store_we   (st_we),
        .store_waddr(st_waddr),
        .store_wdata(st_wdata),
        .job_push   (job_push),
        .job_data   (job_in)
    );

    mpt_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_data(job_in),
        .pop      (q_pop),
        .valid    (q_valid),
        .empty    (q_empty),
        .pop_data (job_out)
    );

    // Three identical copies of the vertex store give three read ports.
    mpt_ram #(.WIDTH(V_W), .DEPTH(MAX_VERTICES)) u_store_a (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(ra), .rdata(qa)
    );
    mpt_ram #(.WIDTH(V_W), .DEPTH(MAX_VERTICES)) u_store_b (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(rb), .rdata(qb)
    );
    mpt_ram #(.WIDTH(V_W), .DEPTH(MAX_VERTICES)) u_store_c (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(rc), .rdata(qc)
    );

    mpt_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(q_valid),
        .job_data (job_out),
        .job_pop  (q_pop),
        .busy     (back_busy),
        .raddr_a  (ra),
        .raddr_b  (rb),
        .raddr_c  (rc),
        .rdata_a  (qa),
        .rdata_b  (qb),
        .rdata_c  (qc),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire
